// File: hdl/assert_macros.svh
// Assertion macros for the RTL of the execute stage.
// No dependencies; SYNTH removes the checks for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define BCX_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define BCX_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define BCX_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCX_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: hdl/bcx_pkg.sv
// Shared types and constants of the byte CPU execute stage.
// No dependencies.
package bcx_pkg;

    localparam int unsigned DATA_DEPTH = 64;
    localparam int unsigned MEM_AW     = $clog2(DATA_DEPTH);

    // bit positions in the status register
    localparam int unsigned FL_C = 4;
    localparam int unsigned FL_V = 3;
    localparam int unsigned FL_N = 2;
    localparam int unsigned FL_S = 1;
    localparam int unsigned FL_Z = 0;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_MOVI = 4'd3,
        OP_BEQZ = 4'd4,
        OP_ANDI = 4'd5,
        OP_EOR  = 4'd6,
        OP_BR   = 4'd7,
        OP_SLC  = 4'd8,
        OP_SRC  = 4'd9,
        OP_LDR  = 4'd10,
        OP_STR  = 4'd11
    } t_opcode;

    typedef struct packed {
        logic               item_valid;
        t_opcode            opcode;
        logic        [5:0]  dest_reg;
        logic signed [7:0]  operand_a;
        logic signed [7:0]  operand_b;
        logic signed [5:0]  immediate;
        logic        [15:0] pc_value;
    } t_instr;

    typedef struct packed {
        logic               reg_write;
        logic        [5:0]  write_reg;
        logic signed [7:0]  write_value;
        logic        [4:0]  status_flags;
        logic               branch_taken;
        logic        [15:0] branch_target;
    } t_result;

endpackage

// File: hdl/bcx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bcx_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bcx_alu.sv
// Result and flag logic for one instruction held in the execute register.
// Depends on bcx_pkg; load data comes from the data RAM read port.
module bcx_alu (
    input  bcx_pkg::t_instr  i_instr,
    input  logic [4:0]       i_flags,
    input  logic [7:0]       i_mem_data,
    output bcx_pkg::t_result o_res
);
    import bcx_pkg::*;

    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  imm8;
    logic [8:0]  sum9;
    logic [7:0]  diff;
    logic [15:0] prod;
    logic [2:0]  shamt;
    logic [15:0] rotl_w;
    logic [15:0] rotr_w;
    logic        add_v;
    logic        sub_v;
    logic        nz_upd;
    t_result     res;

    assign a      = $unsigned(i_instr.operand_a);
    assign b      = $unsigned(i_instr.operand_b);
    assign imm8   = {{2{i_instr.immediate[5]}}, $unsigned(i_instr.immediate)};
    assign sum9   = {1'b0, a} + {1'b0, b};
    assign diff   = a - b;
    assign prod   = a * b;
    assign shamt  = i_instr.immediate[2:0];
    assign rotl_w = {a, a} << shamt;
    assign rotr_w = {a, a} >> shamt;
    assign add_v  = (a[7] == b[7]) && (sum9[7] != a[7]);
    assign sub_v  = (a[7] != b[7]) && (diff[7] != a[7]);

    always_comb begin
        res              = '0;
        res.status_flags = i_flags;
        nz_upd           = 1'b0;
        if (i_instr.item_valid) begin
            case (i_instr.opcode)
                OP_ADD: begin
                    res.reg_write          = 1'b1;
                    res.write_value        = sum9[7:0];
                    res.status_flags[FL_C] = sum9[8];
                    res.status_flags[FL_V] = add_v;
                    res.status_flags[FL_S] = sum9[7] ^ add_v;
                    nz_upd                 = 1'b1;
                end
                OP_SUB: begin
                    res.reg_write          = 1'b1;
                    res.write_value        = diff;
                    res.status_flags[FL_V] = sub_v;
                    res.status_flags[FL_S] = diff[7] ^ sub_v;
                    nz_upd                 = 1'b1;
                end
                OP_MUL: begin
                    res.reg_write   = 1'b1;
                    res.write_value = prod[7:0];
                    nz_upd          = 1'b1;
                end
                OP_MOVI: begin
                    res.reg_write   = 1'b1;
                    res.write_value = imm8;
                end
                OP_BEQZ: begin
                    if (a == 8'd0) begin
                        res.branch_taken  = 1'b1;
                        res.branch_target = i_instr.pc_value + 16'd1
                                          + {{8{imm8[7]}}, imm8};
                    end
                end
                OP_ANDI: begin
                    res.reg_write   = 1'b1;
                    res.write_value = a & imm8;
                    nz_upd          = 1'b1;
                end
                OP_EOR: begin
                    res.reg_write   = 1'b1;
                    res.write_value = a ^ b;
                    nz_upd          = 1'b1;
                end
                OP_BR: begin
                    res.branch_taken  = 1'b1;
                    res.branch_target = {a, b};
                end
                OP_SLC: begin
                    res.reg_write   = 1'b1;
                    res.write_value = rotl_w[15:8];
                    nz_upd          = 1'b1;
                end
                OP_SRC: begin
                    res.reg_write   = 1'b1;
                    res.write_value = rotr_w[7:0];
                    nz_upd          = 1'b1;
                end
                OP_LDR: begin
                    res.reg_write   = 1'b1;
                    res.write_value = i_mem_data;
                end
                OP_STR: begin
                    res.reg_write = 1'b0;
                end
                default: begin
                    res.reg_write = 1'b0;
                end
            endcase
        end
        if (nz_upd) begin
            res.status_flags[FL_N] = res.write_value[7];
            res.status_flags[FL_Z] = (res.write_value == 8'sd0);
        end
        if (res.reg_write) begin
            res.write_reg = i_instr.dest_reg;
        end
    end

    assign o_res = res;

endmodule

// File: hdl/byte_cpu_execute_stage.sv
// Top level of the byte CPU execute stage: input decode, data RAM access,
// execute register, status register and output register.
// Depends on bcx_pkg, bcx_ram, bcx_alu and assert_macros.svh.
//
//  channel  | handshake                     | tdata / tuser
//  ---------+-------------------------------+------------------------------------
//  input    | s_axis_tvalid / s_axis_tready | 48-bit instruction, tuser item_valid
//  output   | m_axis_tvalid / m_axis_tready | 40-bit result, tuser two flags
//
// One item per clock sustained unless the output stalls; an accepted item passes
// the execute register, then the output register. The data RAM read is issued at
// acceptance, stores write the RAM at acceptance, flags update as an item leaves
// the execute register. After reset a clearing pass zeroes every data RAM address,
// with s_axis_tready low. A stalled output holds the execute register and then input.
`include "assert_macros.svh"

module byte_cpu_execute_stage (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] opcode, [9:4] dest_reg, [17:10] operand_a, [25:18] operand_b,
    // [31:26] immediate, [47:32] pc_value
    input  logic [47:0] s_axis_tdata,
    // [0] item_valid
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] write_reg, [13:6] write_value, [18:14] status_flags,
    // [34:19] branch_target, [39:35] zero
    output logic [39:0] m_axis_tdata,
    // [0] reg_write, [1] branch_taken
    output logic [1:0]  m_axis_tuser
);
    import bcx_pkg::*;

    t_instr              in_instr;
    logic                s_acc;
    logic                s1_adv;
    logic                mem_re;
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr;
    logic [MEM_AW-1:0]   mem_raddr;
    logic [7:0]          mem_wdata;
    logic [7:0]          mem_rdata;
    t_result             alu_res;

    logic                r_s1_vld;
    logic                n_s1_vld;
    t_instr              r_s1;
    logic                r_out_vld;
    logic                n_out_vld;
    t_result             r_out;
    logic [4:0]          r_status;
    logic                r_clr_busy;
    logic                n_clr_busy;
    logic [MEM_AW-1:0]   r_clr_addr;
    logic [MEM_AW-1:0]   n_clr_addr;

    assign in_instr.item_valid = s_axis_tuser;
    assign in_instr.opcode     = t_opcode'(s_axis_tdata[3:0]);
    assign in_instr.dest_reg   = s_axis_tdata[9:4];
    assign in_instr.operand_a  = s_axis_tdata[17:10];
    assign in_instr.operand_b  = s_axis_tdata[25:18];
    assign in_instr.immediate  = s_axis_tdata[31:26];
    assign in_instr.pc_value   = s_axis_tdata[47:32];

    assign s1_adv        = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_clr_busy && (!r_s1_vld || s1_adv);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // load/store address is the raw immediate pattern
    assign mem_raddr = MEM_AW'($unsigned(in_instr.immediate));
    assign mem_re    = s_acc && in_instr.item_valid && (in_instr.opcode == OP_LDR);
    assign mem_we    = r_clr_busy
                    || (s_acc && in_instr.item_valid && (in_instr.opcode == OP_STR));
    assign mem_waddr = r_clr_busy ? r_clr_addr : mem_raddr;
    assign mem_wdata = r_clr_busy ? 8'd0 : $unsigned(in_instr.operand_a);

    bcx_ram #(
        .WIDTH (8),
        .DEPTH (DATA_DEPTH)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bcx_alu u_alu (
        .i_instr    (r_s1),
        .i_flags    (r_status),
        .i_mem_data (mem_rdata),
        .o_res      (alu_res)
    );

    always_comb begin
        n_s1_vld   = r_s1_vld;
        n_out_vld  = r_out_vld;
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (s1_adv) begin
            n_s1_vld = 1'b0;
        end
        if (s_acc) begin
            n_s1_vld = 1'b1;
        end
        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end
        if (s1_adv) begin
            n_out_vld = 1'b1;
        end
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == MEM_AW'(DATA_DEPTH - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_status   <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_s1_vld   <= n_s1_vld;
            r_out_vld  <= n_out_vld;
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
            if (s1_adv) begin
                r_status <= alu_res.status_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1 <= in_instr;
        end
        if (s1_adv) begin
            r_out <= alu_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out.branch_target, r_out.status_flags,
                            $unsigned(r_out.write_value), r_out.write_reg};
    assign m_axis_tuser  = {r_out.branch_taken, r_out.reg_write};

    `BCX_ASSERT(a_s1_hold, i_clk, i_rst_n, (r_s1_vld && !s1_adv) |=> (r_s1_vld && $stable(r_s1)), "execute register lost or changed an item while stalled")
    `BCX_ASSERT(a_out_flags, i_clk, i_rst_n, r_out_vld |-> (r_out.status_flags == r_status), "output flags differ from status register")
    `BCX_NEVER(a_clr_item, i_clk, i_rst_n, r_s1_vld && r_clr_busy, "item in flight during RAM clearing pass")
    `BCX_ASSERT(a_full_stall, i_clk, i_rst_n, (r_s1_vld && r_out_vld && !m_axis_tready) |-> !s_axis_tready, "input taken while both stages are full and stalled")

endmodule

// File: tb/tb_byte_cpu_execute_stage.sv
// Self-checking testbench for byte_cpu_execute_stage: directed and random instruction
// items, checked in order against a model of the ALU, flags, branches and data memory.
// Depends on bcx_pkg and the execute stage RTL.

package tb_exec_sb_pkg;
    import bcx_pkg::*;

    class exec_scoreboard;
        t_result    expected_q[$];
        logic [4:0] flags;
        logic [7:0] data_mem[DATA_DEPTH];
        int         n_results;
        int         n_errors;

        function new();
            flags = '0;
            foreach (data_mem[i]) data_mem[i] = 8'h00;
            n_results = 0;
            n_errors  = 0;
        endfunction

        function void report(string msg);
            n_errors++;
            $display("ERROR: %s", msg);
        endfunction

        function logic [4:0] with_nz(logic [4:0] f, logic [7:0] r);
            f[FL_N] = r[7];
            f[FL_Z] = (r == 8'h00);
            return f;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Executes one accepted item against the local flags and memory copy.
        function void note_instr(t_instr ins);
            t_result     res;
            logic [7:0]  a, b, imm8, r;
            logic [8:0]  sum;
            logic [15:0] rot;
            logic [5:0]  addr;
            logic        wr;
            res  = '0;
            wr   = 1'b0;
            r    = 8'h00;
            a    = ins.operand_a;
            b    = ins.operand_b;
            imm8 = {{2{ins.immediate[5]}}, ins.immediate};
            addr = ins.immediate;
            if (ins.item_valid) begin
                case (ins.opcode)
                    OP_ADD: begin
                        sum = {1'b0, a} + {1'b0, b};
                        r = sum[7:0];
                        flags = with_nz(5'b0, r);
                        flags[FL_C] = sum[8];
                        flags[FL_V] = (a[7] == b[7]) && (r[7] != a[7]);
                        flags[FL_S] = flags[FL_N] ^ flags[FL_V];
                        wr = 1'b1;
                    end
                    OP_SUB: begin
                        // carry is left as it was
                        r = a - b;
                        flags = with_nz(flags, r);
                        flags[FL_V] = (a[7] != b[7]) && (r[7] != a[7]);
                        flags[FL_S] = flags[FL_N] ^ flags[FL_V];
                        wr = 1'b1;
                    end
                    OP_MUL: begin
                        r = a * b;
                        flags = with_nz(flags, r);
                        wr = 1'b1;
                    end
                    OP_MOVI: begin
                        r = imm8;
                        wr = 1'b1;
                    end
                    OP_BEQZ: begin
                        if (a == 8'h00) begin
                            res.branch_taken  = 1'b1;
                            res.branch_target = ins.pc_value + 16'd1
                                              + {{10{ins.immediate[5]}}, ins.immediate};
                        end
                    end
                    OP_ANDI: begin
                        r = a & imm8;
                        flags = with_nz(flags, r);
                        wr = 1'b1;
                    end
                    OP_EOR: begin
                        r = a ^ b;
                        flags = with_nz(flags, r);
                        wr = 1'b1;
                    end
                    OP_BR: begin
                        res.branch_taken  = 1'b1;
                        res.branch_target = {a, b};
                    end
                    OP_SLC: begin
                        rot = {a, a} << ins.immediate[2:0];
                        r = rot[15:8];
                        flags = with_nz(flags, r);
                        wr = 1'b1;
                    end
                    OP_SRC: begin
                        rot = {a, a} >> ins.immediate[2:0];
                        r = rot[7:0];
                        flags = with_nz(flags, r);
                        wr = 1'b1;
                    end
                    OP_LDR: begin
                        r = data_mem[addr];
                        wr = 1'b1;
                    end
                    OP_STR: data_mem[addr] = a;
                    default: ;
                endcase
            end
            res.reg_write    = wr;
            res.write_reg    = wr ? ins.dest_reg : 6'd0;
            res.write_value  = wr ? r : 8'h00;
            res.status_flags = flags;
            expected_q.push_back(res);
        endfunction

        function void compare(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %h, want %h", n_results, field, got, want));
        endfunction

        function void check_result(t_result got);
            t_result want;
            n_results++;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", n_results));
                return;
            end
            want = expected_q.pop_front();
            compare("reg_write", got.reg_write, want.reg_write);
            compare("write_reg", got.write_reg, want.write_reg);
            compare("write_value", $unsigned(got.write_value), $unsigned(want.write_value));
            compare("status_flags", got.status_flags, want.status_flags);
            compare("branch_taken", got.branch_taken, want.branch_taken);
            compare("branch_target", got.branch_target, want.branch_target);
        endfunction

        function void check_drained();
            if (expected_q.size() != 0)
                report($sformatf("%0d expected results never arrived", expected_q.size()));
        endfunction
    endclass

endpackage

module tb_byte_cpu_execute_stage;
    timeunit 1ns;
    timeprecision 1ps;
    import bcx_pkg::*;
    import tb_exec_sb_pkg::*;

    // random items after the directed ones, about 1550 items in all
    localparam int N_RANDOM_ITEMS = 1524;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;    // opcode, dest_reg, operand_a, operand_b, immediate, pc
    logic        s_axis_tuser  = 1'b0;  // item_valid
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // write_reg, write_value, flags, branch_target, pad
    logic [1:0]  m_axis_tuser;          // reg_write, branch_taken

    exec_scoreboard sb = new();

    byte_cpu_execute_stage dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.reg_write     = m_axis_tuser[0];
            got.branch_taken  = m_axis_tuser[1];
            got.write_reg     = m_axis_tdata[5:0];
            got.write_value   = m_axis_tdata[13:6];
            got.status_flags  = m_axis_tdata[18:14];
            got.branch_target = m_axis_tdata[34:19];
            sb.check_result(got);
        end
    end

    // Output stalls: modes of random length, plus one long hold-off that backs
    // the pipe up into the input.
    initial begin : result_sink
        int  mode;
        int  left;
        bit  held;
        mode = 0;
        left = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sb.n_results >= 300) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (250) @(posedge i_clk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic t_instr make_instr(bit valid, logic [3:0] op, logic [5:0] rd,
                                          logic [7:0] a, logic [7:0] b, logic [5:0] imm,
                                          logic [15:0] pc);
        t_instr ins;
        ins.item_valid = valid;
        ins.opcode     = t_opcode'(op);
        ins.dest_reg   = rd;
        ins.operand_a  = a;
        ins.operand_b  = b;
        ins.immediate  = imm;
        ins.pc_value   = pc;
        return ins;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return $urandom_range(0, 1) ? 8'h7f : 8'h80;
            2:       return $urandom_range(0, 1) ? 8'hff : 8'h01;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_instr random_instr();
        logic [3:0] op;
        logic [5:0] imm;
        logic [7:0] a;
        bit         valid;
        valid = ($urandom_range(0, 99) >= 8);
        if ($urandom_range(0, 99) < 6)
            op = 4'($urandom_range(int'(OP_STR) + 1, 15));
        else
            op = 4'($urandom_range(0, int'(OP_STR)));
        imm = 6'($urandom);
        // small address pool so loads often see fresh stores
        if ((op == OP_LDR || op == OP_STR) && $urandom_range(0, 1))
            imm = 6'($urandom_range(0, 7));
        a = pick_byte();
        if (op == OP_BEQZ && $urandom_range(0, 1)) a = 8'h00;
        return make_instr(valid, op, 6'($urandom), a, pick_byte(), imm, 16'($urandom));
    endfunction

    task automatic send_instr(t_instr ins);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ins.item_valid;
        s_axis_tdata  <= {ins.pc_value, ins.immediate, ins.operand_b, ins.operand_a,
                          ins.dest_reg, ins.opcode};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_instr(ins);
    endtask

    initial begin : stimulus
        t_instr ins;
        int     n_sent;
        int     burst;
        int     gap;
        int     drain;
        bit     paused;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_instr(make_instr(1, OP_ADD,  6'd0,  8'h7f, 8'h01, 6'h00, 16'h0000));
        send_instr(make_instr(1, OP_ADD,  6'd63, 8'h80, 8'h80, 6'h00, 16'hffff));
        send_instr(make_instr(1, OP_ADD,  6'd1,  8'hff, 8'h01, 6'h3f, 16'h0001));
        send_instr(make_instr(1, OP_SUB,  6'd63, 8'h80, 8'h01, 6'h00, 16'h0002));
        send_instr(make_instr(1, OP_SUB,  6'd2,  8'h00, 8'h00, 6'h00, 16'h0003));
        send_instr(make_instr(1, OP_MUL,  6'd3,  8'h10, 8'h10, 6'h00, 16'h0004));
        send_instr(make_instr(1, OP_MUL,  6'd4,  8'hff, 8'hff, 6'h00, 16'h0005));
        send_instr(make_instr(1, OP_MOVI, 6'd5,  8'h00, 8'h00, 6'h20, 16'h0006));
        send_instr(make_instr(1, OP_MOVI, 6'd6,  8'h00, 8'h00, 6'h1f, 16'h0007));
        // branch offsets that wrap the 16-bit pc both ways
        send_instr(make_instr(1, OP_BEQZ, 6'd7,  8'h00, 8'h55, 6'h20, 16'h0000));
        send_instr(make_instr(1, OP_BEQZ, 6'd8,  8'h00, 8'h00, 6'h1f, 16'hffff));
        send_instr(make_instr(1, OP_BEQZ, 6'd9,  8'h01, 8'h00, 6'h05, 16'h1234));
        send_instr(make_instr(1, OP_ANDI, 6'd10, 8'hff, 8'h00, 6'h20, 16'h0008));
        send_instr(make_instr(1, OP_EOR,  6'd11, 8'haa, 8'h55, 6'h00, 16'h0009));
        send_instr(make_instr(1, OP_EOR,  6'd12, 8'h5a, 8'h5a, 6'h00, 16'h000a));
        send_instr(make_instr(1, OP_BR,   6'd13, 8'h80, 8'hff, 6'h00, 16'h000b));
        send_instr(make_instr(1, OP_SLC,  6'd14, 8'h81, 8'h00, 6'h07, 16'h000c));
        send_instr(make_instr(1, OP_SLC,  6'd15, 8'h81, 8'h00, 6'h38, 16'h000d));
        send_instr(make_instr(1, OP_SRC,  6'd16, 8'h01, 8'h00, 6'h01, 16'h000e));
        send_instr(make_instr(1, OP_SRC,  6'd17, 8'h80, 8'h00, 6'h3f, 16'h000f));
        send_instr(make_instr(1, OP_STR,  6'd18, 8'ha5, 8'h00, 6'h3f, 16'h0010));
        send_instr(make_instr(1, OP_STR,  6'd19, 8'h5a, 8'h00, 6'h00, 16'h0011));
        send_instr(make_instr(1, OP_LDR,  6'd20, 8'h00, 8'h00, 6'h3f, 16'h0012));
        send_instr(make_instr(1, OP_LDR,  6'd21, 8'h00, 8'h00, 6'h11, 16'h0013));
        send_instr(make_instr(0, OP_ADD,  6'd22, 8'h7f, 8'h7f, 6'h00, 16'h0014));
        send_instr(make_instr(1, 4'hf,    6'd23, 8'h00, 8'h00, 6'h00, 16'h0015));

        n_sent = 0;
        paused = 1'b0;
        while (n_sent < N_RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n_sent < N_RANDOM_ITEMS; k++) begin
                ins = random_instr();
                send_instr(ins);
                n_sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (!paused && n_sent >= N_RANDOM_ITEMS / 2) begin
                // let the pipe drain completely once
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end else if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= {16'($urandom), $urandom};
                repeat (gap) @(posedge i_clk);
            end
        end

        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (sb.pending() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        sb.check_drained();
        if (sb.n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
